>>> src/lzcd_pkg.sv
// lzcd_pkg: shared types and constants of the lz control byte decompressor
// no dependencies; used by lzcd_ring, lzcd_seq and the top level
package lzcd_pkg;

  localparam int unsigned HistoryDepth = 4096;
  localparam int unsigned RingAw       = 12;
  localparam int unsigned LenW         = 9;
  localparam int unsigned CntW         = 4;
  localparam int unsigned OutBytesW    = 64;

  localparam logic [3:0]      FlagsPerCtrl = 4'd8;
  localparam logic [3:0]      LenEscape    = 4'hf;
  localparam logic [LenW-1:0] ShortLenBias = 9'd3;
  localparam logic [LenW-1:0] LongLenBias  = 9'd18;

  typedef struct packed {
    logic       end_of_block;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [OutBytesW-1:0] out_bytes;
    logic [CntW-1:0]      byte_count;
    logic                 run_last;
    logic                 block_end;
    logic                 truncated;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [RingAw-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [RingAw-1:0] raddr;
  } ring_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_WR,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_ITEM,
    PH_T1,
    PH_T2
  } phase_e;

endpackage

>>> src/lz_control_byte_decompressor.sv
// Byte-serial LZSS decompressor, 12-bit offsets, 4096-byte history ring.
// A plain byte, a literal, a control byte or a tag byte is accepted and then
// decoded. A tag copy then does a ring read, then a ring write, for each copied
// byte, and emits a result word after each group of up to BYTES_PER_RESULT
// bytes and at the end of a 3..273 byte copy. The input is stalled while a byte
// is worked on, and a finished result word waits in the output register without
// holding up the next input byte. Ring entries not yet written read as zero
// through a write pointer and wrap mark, so no clearing pass follows reset. The
// user must write the mode register through the config port only while the block
// is idle; the block itself does not enforce this.
module lz_control_byte_decompressor #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lzcd_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lzcd_pkg::out_t out_word_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  logic                raw_q;
  logic                out_valid_q;
  lzcd_pkg::out_t      out_word_q;
  logic                out_free;
  logic                emit;
  lzcd_pkg::out_t      res;
  lzcd_pkg::ring_req_t ring_req;
  logic [7:0]          ring_rdata;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        raw_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  lzcd_seq #(
    .BYTES_PER_RESULT(BYTES_PER_RESULT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .raw_i        (raw_q),
    .out_free_i   (out_free),
    .emit_o       (emit),
    .res_o        (res),
    .ring_req_o   (ring_req),
    .ring_rdata_i (ring_rdata)
  );

  lzcd_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

endmodule

>>> src/lzcd_ring.sv
// lzcd_ring: 4096 x 8 history ring, one write and one registered read per cycle
// depends on lzcd_pkg for the request struct
module lzcd_ring (
  input  logic                clk_i,
  input  lzcd_pkg::ring_req_t req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [lzcd_pkg::HistoryDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lzcd_seq.sv
// lzcd_seq: parser and copy sequencer driving the single history ring port
// depends on lzcd_pkg; the result register lives in the top level
module lzcd_seq #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lzcd_pkg::in_t       in_word_i,
  input  logic                raw_i,
  input  logic                out_free_i,
  output logic                emit_o,
  output lzcd_pkg::out_t      res_o,
  output lzcd_pkg::ring_req_t ring_req_o,
  input  logic [7:0]          ring_rdata_i
);

  localparam int unsigned Aw   = lzcd_pkg::RingAw;
  localparam int unsigned LenW = lzcd_pkg::LenW;
  localparam int unsigned CntW = lzcd_pkg::CntW;
  localparam int unsigned OutW = lzcd_pkg::OutBytesW;
  localparam logic [CntW-1:0] ChunkBytes = CntW'(BYTES_PER_RESULT);

  lzcd_pkg::state_e state_q, state_d;
  lzcd_pkg::phase_e phase_q, phase_d, ph_n;

  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [7:0]      flag_shift_q, flag_shift_d, fs_n;
  logic [3:0]      flags_left_q, flags_left_d, fl_n;
  logic [7:0]      held_q, held_d, held_n;
  logic [Aw-1:0]   off_q, off_d, off_n;
  logic [Aw-1:0]   wp_q, wp_d;
  logic            wrapped_q, wrapped_d;
  logic [LenW-1:0] len_q, len_d, len_n;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [OutW-1:0] acc_q, acc_d;
  logic            srcok_q, srcok_d;
  logic            lit, copy;
  logic [Aw-1:0]   src;
  logic [7:0]      cbyte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzcd_pkg::S_IDLE;
      phase_q      <= lzcd_pkg::PH_ITEM;
      flag_shift_q <= '0;
      flags_left_q <= '0;
      held_q       <= '0;
      off_q        <= '0;
      wp_q         <= '0;
      wrapped_q    <= 1'b0;
      last_q       <= 1'b0;
      len_q        <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      flag_shift_q <= flag_shift_d;
      flags_left_q <= flags_left_d;
      held_q       <= held_d;
      off_q        <= off_d;
      wp_q         <= wp_d;
      wrapped_q    <= wrapped_d;
      last_q       <= last_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    acc_q   <= acc_d;
    srcok_q <= srcok_d;
  end

  assign src   = wp_q - off_q;
  assign cbyte = srcok_q ? ring_rdata_i : 8'h00;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    flag_shift_d = flag_shift_q;
    flags_left_d = flags_left_q;
    held_d       = held_q;
    off_d        = off_q;
    wp_d         = wp_q;
    wrapped_d    = wrapped_q;
    byte_d       = byte_q;
    last_d       = last_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    srcok_d      = srcok_q;
    ph_n         = phase_q;
    fs_n         = flag_shift_q;
    fl_n         = flags_left_q;
    held_n       = held_q;
    off_n        = off_q;
    len_n        = len_q;
    lit          = 1'b0;
    copy         = 1'b0;
    emit_o       = 1'b0;
    res_o        = '0;
    ring_req_o   = '0;
    in_stall_o   = (state_q != lzcd_pkg::S_IDLE);

    case (state_q)
      lzcd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          byte_d  = in_word_i.in_byte;
          last_d  = in_word_i.end_of_block;
          state_d = lzcd_pkg::S_DECODE;
        end
      end

      lzcd_pkg::S_DECODE: begin
        if (raw_i) begin
          lit = 1'b1;
        end else if (phase_q == lzcd_pkg::PH_ITEM && flags_left_q == '0) begin
          fs_n = byte_q;
          fl_n = lzcd_pkg::FlagsPerCtrl;
        end else if (phase_q == lzcd_pkg::PH_ITEM && !flag_shift_q[0]) begin
          lit  = 1'b1;
          fs_n = {1'b0, flag_shift_q[7:1]};
          fl_n = flags_left_q - 4'd1;
        end else if (phase_q == lzcd_pkg::PH_ITEM) begin
          held_n = byte_q;
          ph_n   = lzcd_pkg::PH_T1;
        end else if (phase_q == lzcd_pkg::PH_T1) begin
          off_n = {held_q[7:4], byte_q};
          if (held_q[3:0] == lzcd_pkg::LenEscape) begin
            ph_n = lzcd_pkg::PH_T2;
          end else begin
            copy  = 1'b1;
            len_n = LenW'(held_q[3:0]) + lzcd_pkg::ShortLenBias;
          end
        end else begin
          copy  = 1'b1;
          len_n = LenW'(byte_q) + lzcd_pkg::LongLenBias;
        end

        if (copy) begin
          off_d   = off_n;
          len_d   = len_n;
          cnt_d   = '0;
          acc_d   = '0;
          state_d = lzcd_pkg::S_RD;
        end else if (!last_q && !lit) begin
          flag_shift_d = fs_n;
          flags_left_d = fl_n;
          phase_d      = ph_n;
          held_d       = held_n;
          off_d        = off_n;
          state_d      = lzcd_pkg::S_IDLE;
        end else if (out_free_i) begin
          emit_o          = 1'b1;
          res_o.run_last  = 1'b1;
          res_o.block_end = last_q;
          res_o.truncated = last_q && !lit && (ph_n != lzcd_pkg::PH_ITEM);
          if (lit) begin
            ring_req_o.we    = 1'b1;
            ring_req_o.waddr = wp_q;
            ring_req_o.wdata = byte_q;
            wp_d             = wp_q + Aw'(1);
            wrapped_d        = wrapped_q || (wp_q == '1);
            res_o.out_bytes  = OutW'(byte_q);
            res_o.byte_count = CntW'(1);
          end
          if (last_q) begin
            flag_shift_d = '0;
            flags_left_d = '0;
            phase_d      = lzcd_pkg::PH_ITEM;
            held_d       = '0;
            off_d        = '0;
          end else begin
            flag_shift_d = fs_n;
            flags_left_d = fl_n;
            phase_d      = ph_n;
            held_d       = held_n;
            off_d        = off_n;
          end
          state_d = lzcd_pkg::S_IDLE;
        end
      end

      lzcd_pkg::S_RD: begin
        ring_req_o.re    = 1'b1;
        ring_req_o.raddr = src;
        srcok_d          = wrapped_q || (src < wp_q);
        state_d          = lzcd_pkg::S_WR;
      end

      lzcd_pkg::S_WR: begin
        ring_req_o.we                    = 1'b1;
        ring_req_o.waddr                 = wp_q;
        ring_req_o.wdata                 = cbyte;
        wp_d                             = wp_q + Aw'(1);
        wrapped_d                        = wrapped_q || (wp_q == '1);
        acc_d[{cnt_q[2:0], 3'b000} +: 8] = cbyte;
        cnt_d                            = cnt_q + CntW'(1);
        len_d                            = len_q - LenW'(1);
        if (cnt_q + CntW'(1) == ChunkBytes || len_q == LenW'(1)) begin
          state_d = lzcd_pkg::S_EMIT;
        end else begin
          state_d = lzcd_pkg::S_RD;
        end
      end

      lzcd_pkg::S_EMIT: begin
        if (out_free_i) begin
          emit_o           = 1'b1;
          res_o.out_bytes  = acc_q;
          res_o.byte_count = cnt_q;
          res_o.run_last   = (len_q == '0);
          res_o.block_end  = last_q && (len_q == '0);
          acc_d            = '0;
          cnt_d            = '0;
          if (len_q == '0) begin
            if (last_q) begin
              flag_shift_d = '0;
              flags_left_d = '0;
              held_d       = '0;
              off_d        = '0;
            end else begin
              flag_shift_d = {1'b0, flag_shift_q[7:1]};
              flags_left_d = flags_left_q - 4'd1;
            end
            phase_d = lzcd_pkg::PH_ITEM;
            state_d = lzcd_pkg::S_IDLE;
          end else begin
            state_d = lzcd_pkg::S_RD;
          end
        end
      end

      default: begin
        state_d = lzcd_pkg::S_IDLE;
      end
    endcase
  end

endmodule
